FILE: rtl/core/bpbu_pkg.sv
// bpbu_pkg: shared types, register map and helper functions for the
// band pixel byte unpacker. No dependencies.

package bpbu_pkg;

	localparam int MaxBands   = 8;
	localparam int PixelBytes = 4;
	localparam int WordW      = 8 * PixelBytes;

	// register indexes on the configuration port (byte address = 8 * index)
	typedef enum logic [1:0] {
		REG_BAND_COUNT = 2'd0,
		REG_BYTE_ORDER = 2'd1,
		REG_BAND_BYTES = 2'd2,
		REG_BAND_BITS  = 2'd3
	} reg_idx_t;

	localparam logic [3:0]  BandCountReset = 4'd1;
	localparam logic        ByteOrderReset = 1'b0;
	localparam logic [15:0] BandBytesReset = 16'h0000;
	localparam logic [39:0] BandBitsReset  = 40'h39CE739CE7;

	typedef struct packed {
		logic [3:0]  band_count;
		logic        byte_order;
		logic [15:0] band_bytes;
		logic [39:0] band_bits;
	} cfg_t;

	// effective bands per vector: zero reads as one, clipped to the maximum
	function automatic logic [3:0] bands_in_vector(input logic [3:0] n);
		logic [3:0] r;
		r = n;
		if (n == 4'd0) r = 4'd1;
		if (n > 4'(MaxBands)) r = 4'(MaxBands);
		return r;
	endfunction

	// mask with (field + 1) low bits set
	function automatic logic [WordW-1:0] bit_mask(input logic [4:0] field);
		logic [WordW:0] full;
		full = ({{WordW{1'b0}}, 1'b1} << ({1'b0, field} + 6'd1)) - 1'b1;
		return full[WordW-1:0];
	endfunction

endpackage

FILE: rtl/core/bpbu_regs.sv
// bpbu_regs: APB-style configuration registers of the unpacker.
// Depends on bpbu_pkg for the register map and the cfg_t struct.

module bpbu_regs import bpbu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[4:3]);
	assign cfg    = cfg_q;

	// register writes on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_count <= BandCountReset;
			cfg_q.byte_order <= ByteOrderReset;
			cfg_q.band_bytes <= BandBytesReset;
			cfg_q.band_bits  <= BandBitsReset;
		end else if (wr_en) begin
			unique case (idx)
				REG_BAND_COUNT: cfg_q.band_count <= pwdata[3:0];
				REG_BYTE_ORDER: cfg_q.byte_order <= pwdata[0];
				REG_BAND_BYTES: cfg_q.band_bytes <= pwdata[15:0];
				REG_BAND_BITS:  cfg_q.band_bits  <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_BAND_COUNT: prdata = {60'd0, cfg_q.band_count};
			REG_BYTE_ORDER: prdata = {63'd0, cfg_q.byte_order};
			REG_BAND_BYTES: prdata = {48'd0, cfg_q.band_bytes};
			REG_BAND_BITS:  prdata = {24'd0, cfg_q.band_bits};
			default:        prdata = 64'd0;
		endcase
	end

endmodule

FILE: rtl/core/band_pixel_byte_unpacker.sv
// band_pixel_byte_unpacker: top level, input register, pixel gathering
// and result register. Depends on bpbu_pkg and bpbu_regs.

// Takes one raw byte per cycle on the s_ stream (tlast marks the end of a
// read) while the m_ stream does not stall, and emits assembled pixels on
// the m_ stream. An accepted byte passes through the input register and
// then the result register, around the combinational gather step.
// A pixel is emitted on the byte that completes it; m_tlast marks the last
// pixel of a vector. When a read ends inside a vector one error result is
// emitted instead (pixel zero, m_tuser[3] set) and the vector is dropped.
// Configure over APB only while the stream is idle; no clearing pass runs
// after reset.

module band_pixel_byte_unpacker import bpbu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// raw byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] raw_byte
	input  logic        s_tlast,   // end_of_read
	// pixel stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] pixel_value
	output logic        m_tlast,   // vector_end
	output logic [3:0]  m_tuser    // [2:0] band_index, [3] partial_error
);

	cfg_t cfg;

	bpbu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// gather state
	logic [2:0]       band_q;
	logic [1:0]       gathered_q;
	logic [WordW-1:0] partial_q;

	// result register
	logic             out_valid_q;
	logic [WordW-1:0] out_pixel_q;
	logic [2:0]       out_band_q;
	logic             out_vend_q;
	logic             out_err_q;

	logic [3:0]       nb;
	logic [1:0]       need_m1;
	logic [4:0]       bits_m1;
	logic [WordW-1:0] word;
	logic             pixel_done;
	logic             vec_done;
	logic             is_err;
	logic             has_result;
	logic             adv;

	// per-band fields and the assembled word
	always_comb begin
		nb         = bands_in_vector(cfg.band_count);
		need_m1    = cfg.band_bytes[2*band_q +: 2];
		bits_m1    = cfg.band_bits[5*band_q +: 5];
		if (cfg.byte_order)
			word = {partial_q[WordW-9:0], byte_s1};
		else
			word = partial_q | (WordW'(byte_s1) << {gathered_q, 3'b000});
		pixel_done = gathered_q >= need_m1;
		vec_done   = pixel_done && (({1'b0, band_q} + 4'd1) >= nb);
		is_err     = last_s1 && !vec_done;
		has_result = is_err || pixel_done;
	end

	// stage advances when its result, if any, has room
	assign adv      = valid_s1 && (!has_result || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// gather state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q     <= 3'd0;
			gathered_q <= 2'd0;
			partial_q  <= '0;
		end else if (adv) begin
			if (is_err) begin
				band_q     <= 3'd0;
				gathered_q <= 2'd0;
				partial_q  <= '0;
			end else if (!pixel_done) begin
				partial_q  <= word;
				gathered_q <= gathered_q + 2'd1;
			end else begin
				partial_q  <= '0;
				gathered_q <= 2'd0;
				band_q     <= vec_done ? 3'd0 : band_q + 3'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			out_band_q  <= band_q;
			out_err_q   <= is_err;
			out_vend_q  <= !is_err && vec_done;
			out_pixel_q <= is_err ? '0 : (word & bit_mask(bits_m1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pixel_q;
	assign m_tlast  = out_vend_q;
	assign m_tuser  = {out_err_q, out_band_q};

	// an error result carries no pixel and never ends a vector
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> !m_tlast && m_tdata == '0)
		else $error("error result with pixel data or vector end");

	// the end of a read always leaves the gather state cleared
	a_read_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> band_q == 3'd0 && gathered_q == 2'd0 && partial_q == '0)
		else $error("gather state not cleared at end of read");

	// no gathered bytes means no partial word
	a_partial_empty: assert property (@(posedge clk) disable iff (!arst_n)
		gathered_q == 2'd0 |-> partial_q == '0)
		else $error("partial word held with no bytes gathered");

endmodule
